>>> rtl/shl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shl_pkg
// Shared types, widths and fixed-point constants of the SH lighting block.
// ----------------------------------------------------------------------------
package shl_pkg;

	localparam int CW    = 40;                       // coefficient width
	localparam int BANDS = 9;
	localparam int CHANS = 3;
	localparam int BIW   = $clog2(BANDS + 1);        // band counter width
	localparam int BW    = 21;                       // basis / weight width
	localparam int HW    = (CW > 32) ? CW - 32 : 1;  // upper coefficient part
	localparam int CPW   = BW + 17;                  // colour product width
	localparam int SUMW  = ((CW > CPW) ? CW : CPW) + 1;
	localparam int ALW   = BW + 33 + 4;              // low-part accumulator
	localparam int AHW   = BW + HW + 4;              // high-part accumulator

	// Q.16 constants
	localparam logic signed [18:0] K_B1  = 19'sd18487;
	localparam logic signed [18:0] K_B2  = 19'sd32021;
	localparam logic signed [18:0] K_B3  = 19'sd71601;
	localparam logic signed [18:0] K_B4  = 19'sd20670;
	localparam logic signed [18:0] K_B5  = 19'sd35801;
	localparam logic signed [18:0] K_AMB = 19'sd73949;
	localparam logic signed [18:0] K_E1  = 19'sd28118;
	localparam logic signed [18:0] K_E2  = 19'sd33532;
	localparam logic signed [18:0] K_E3  = 19'sd48701;
	localparam logic signed [18:0] K_E4  = 19'sd58080;
	localparam logic signed [18:0] K_E5  = 19'sd16234;

	typedef enum logic [1:0] {
		OP_DIR = 2'd0,
		OP_AMB = 2'd1,
		OP_CLR = 2'd2,
		OP_QRY = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_PROD,
		ST_RUN,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic           load;
		logic           clear;
		logic           prod;
		logic           basis_en;
		logic           apply_en;
		logic           fin;
		logic [BIW-1:0] band;
	} cmd_t;

endpackage

>>> rtl/sh_lighting_accumulate_and_irradiance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sh_lighting_accumulate_and_irradiance
// Order-2 spherical-harmonic lighting store (9 bands x RGB) with
// irradiance query.
// ----------------------------------------------------------------------------
// Usage: an input request (op, direction, colour) is taken when in_valid is
// high and in_stall low. Only a query (op 3) returns a result on the output
// channel (irr_red/green/blue), held while out_stall is high.
// Requests are handled one at a time; the band loop runs through one shared
// basis unit, one band per cycle, updating or weighting all three channels.
// A query result waits in the output register; the next request is accepted
// meanwhile, and a following query only finishes once that result is taken.
// Reset clears the coefficient store and all control state; no result is
// pending after reset.
// ----------------------------------------------------------------------------
module sh_lighting_accumulate_and_irradiance import shl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         op,
	input  logic signed [15:0] dir_x,
	input  logic signed [15:0] dir_y,
	input  logic signed [15:0] dir_z,
	input  logic [15:0]        red_in,
	input  logic [15:0]        green_in,
	input  logic [15:0]        blue_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] irr_red,
	output logic signed [31:0] irr_green,
	output logic signed [31:0] irr_blue
);

	cmd_t cmd;

	shl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	shl_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.op        (op),
		.dir_x     (dir_x),
		.dir_y     (dir_y),
		.dir_z     (dir_z),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.irr_red   (irr_red),
		.irr_green (irr_green),
		.irr_blue  (irr_blue)
	);

	// one request at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request accepted while previous one in progress");

	// a result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> (!out_valid || !out_stall))
		else $error("result register overwritten while stalled");

	// band updates never collide with clear or load
	a_apply_alone: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply_en |-> (!cmd.clear && !cmd.load))
		else $error("band update overlaps clear or load");

endmodule

>>> rtl/shl_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shl_dp
// Datapath: direction products, per-band basis unit, coefficient store,
// three-channel update / weighted accumulation and output rounding.
// ----------------------------------------------------------------------------
module shl_dp import shl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	input  logic [1:0]         op,
	input  logic signed [15:0] dir_x,
	input  logic signed [15:0] dir_y,
	input  logic signed [15:0] dir_z,
	input  logic [15:0]        red_in,
	input  logic [15:0]        green_in,
	input  logic [15:0]        blue_in,
	output logic signed [31:0] irr_red,
	output logic signed [31:0] irr_green,
	output logic signed [31:0] irr_blue
);

	localparam logic signed [SUMW-1:0] CMAX = (SUMW'(1) <<< (CW - 1)) - SUMW'(1);
	localparam logic signed [SUMW-1:0] CMIN = -CMAX - SUMW'(1);
	localparam logic signed [63:0] HI_LIM = 64'sd1 <<< 36;

	op_t                op_q;
	logic signed [15:0] x_q, y_q, z_q;
	logic [15:0]        col_q [CHANS];
	logic signed [31:0] xx_q, yy_q, zz_q, xy_q, yz_q, xz_q;
	logic signed [BW-1:0] b_s1;
	logic [BIW-1:0]       band_s1;
	logic signed [CW-1:0] store_q [BANDS][CHANS];
	logic signed [ALW-1:0] acc_lo_q [CHANS];
	logic signed [AHW-1:0] acc_hi_q [CHANS];
	logic signed [31:0]    irr_q [CHANS];

	logic                 qf;
	logic signed [33:0]   term;
	logic signed [18:0]   kc;
	logic                 s28;
	logic signed [BW-1:0] boff;
	logic signed [52:0]   bprod;
	logic signed [52:0]   brnd;
	logic signed [BW-1:0] basis;

	logic signed [CW-1:0]    new_c [CHANS];
	logic signed [ALW-1:0]   plo [CHANS];
	logic signed [AHW-1:0]   phi [CHANS];
	logic signed [31:0]      res [CHANS];

	assign qf = (op_q == OP_QRY);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= op_t'(op);
			x_q      <= dir_x;
			y_q      <= dir_y;
			z_q      <= dir_z;
			col_q[0] <= red_in;
			col_q[1] <= green_in;
			col_q[2] <= blue_in;
		end
		if (cmd.prod) begin
			xx_q <= x_q * x_q;
			yy_q <= y_q * y_q;
			zz_q <= z_q * z_q;
			xy_q <= x_q * y_q;
			yz_q <= y_q * z_q;
			xz_q <= x_q * z_q;
		end
		if (cmd.basis_en) begin
			b_s1    <= basis;
			band_s1 <= cmd.band;
		end
	end

	// basis / weight for one band: rnd(k * term, s) + offset
	always_comb begin
		term = 34'sd16384;
		kc   = qf ? K_E4 : ((op_q == OP_AMB) ? K_AMB : K_B1);
		s28  = 1'b0;
		boff = '0;
		case (cmd.band)
			4'd1: begin
				term = 34'(y_q);
				kc   = qf ? 19'(K_E2 * 2) : K_B2;
			end
			4'd2: begin
				term = 34'(z_q);
				kc   = qf ? 19'(K_E2 * 2) : K_B2;
			end
			4'd3: begin
				term = 34'(x_q);
				kc   = qf ? 19'(K_E2 * 2) : K_B2;
			end
			4'd4: begin
				term = 34'(xy_q);
				kc   = qf ? 19'(K_E1 * 2) : K_B3;
				s28  = 1'b1;
			end
			4'd5: begin
				term = 34'(yz_q);
				kc   = qf ? 19'(K_E1 * 2) : K_B3;
				s28  = 1'b1;
			end
			4'd6: begin
				term = qf ? 34'(zz_q) : (34'(zz_q) * 34'sd3 - 34'sd268435456);
				kc   = qf ? K_E3 : K_B4;
				s28  = 1'b1;
				boff = qf ? -BW'(K_E5) : '0;
			end
			4'd7: begin
				term = 34'(xz_q);
				kc   = qf ? 19'(K_E1 * 2) : K_B3;
				s28  = 1'b1;
			end
			4'd8: begin
				term = 34'(xx_q) - 34'(yy_q);
				kc   = qf ? K_E1 : K_B5;
				s28  = 1'b1;
			end
			default: begin
				term = 34'sd16384;
			end
		endcase
		bprod = term * kc;
		brnd  = s28 ? ((bprod + (53'sd1 <<< 27)) >>> 28)
		            : ((bprod + (53'sd1 <<< 13)) >>> 14);
		basis = BW'(brnd) + boff;
	end

	// per-channel store update and query partial products
	always_comb begin
		logic signed [CPW-1:0]    cprod;
		logic signed [CPW-1:0]    contrib;
		logic signed [SUMW-1:0]   sum;
		logic signed [32+HW-1:0]  cext;
		logic signed [CW-1:0]     cur;
		for (int c = 0; c < CHANS; c++) begin
			cur     = store_q[band_s1][c];
			cprod   = b_s1 * $signed({1'b0, col_q[c]});
			contrib = (cprod + CPW'(128)) >>> 8;
			sum     = SUMW'(cur) + SUMW'(contrib);
			if (sum > CMAX)
				new_c[c] = CW'(CMAX);
			else if (sum < CMIN)
				new_c[c] = CW'(CMIN);
			else
				new_c[c] = CW'(sum);
			cext   = (32 + HW)'(cur);
			plo[c] = ALW'(b_s1 * $signed({1'b0, cext[31:0]}));
			phi[c] = AHW'(b_s1 * $signed(cext[32+HW-1:32]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < BANDS; b++)
				for (int c = 0; c < CHANS; c++)
					store_q[b][c] <= '0;
		end else if (cmd.clear) begin
			for (int b = 0; b < BANDS; b++)
				for (int c = 0; c < CHANS; c++)
					store_q[b][c] <= '0;
		end else if (cmd.apply_en && !qf) begin
			for (int c = 0; c < CHANS; c++)
				store_q[band_s1][c] <= new_c[c];
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < CHANS; c++) begin
			if (cmd.prod) begin
				acc_lo_q[c] <= '0;
				acc_hi_q[c] <= '0;
			end else if (cmd.apply_en && qf) begin
				acc_lo_q[c] <= acc_lo_q[c] + plo[c];
				acc_hi_q[c] <= acc_hi_q[c] + phi[c];
			end
		end
	end

	// round by 16 bits and saturate to 32
	always_comb begin
		logic signed [ALW-1:0] f;
		logic signed [63:0]    ah;
		logic signed [63:0]    q;
		for (int c = 0; c < CHANS; c++) begin
			f  = (acc_lo_q[c] + ALW'(32768)) >>> 16;
			ah = 64'(acc_hi_q[c]);
			q  = (ah <<< 16) + 64'(f);
			if (ah >= HI_LIM)
				res[c] = 32'sh7FFFFFFF;
			else if (ah <= -HI_LIM)
				res[c] = 32'sh80000000;
			else if (q > 64'sd2147483647)
				res[c] = 32'sh7FFFFFFF;
			else if (q < -64'sd2147483648)
				res[c] = 32'sh80000000;
			else
				res[c] = 32'(q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			for (int c = 0; c < CHANS; c++)
				irr_q[c] <= res[c];
		end
	end

	assign irr_red   = irr_q[0];
	assign irr_green = irr_q[1];
	assign irr_blue  = irr_q[2];

endmodule

>>> rtl/shl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shl_ctrl
// Controller: accepts requests, sequences the band loop, owns the result
// valid flag.
// ----------------------------------------------------------------------------
module shl_ctrl import shl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] op,
	output logic       out_valid,
	input  logic       out_stall,
	output cmd_t       cmd
);

	state_t         state_q, state_d;
	op_t            op_q;
	logic [BIW-1:0] cnt_q, cnt_d;
	logic [BIW-1:0] last;
	logic           out_valid_q;

	// ambient touches band Y00 only
	assign last = (op_q == OP_AMB) ? '0 : BIW'(BANDS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = (op_t'(op) == OP_CLR) ? ST_CLEAR : ST_PROD;
				end
			end
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				state_d   = ST_IDLE;
			end
			ST_PROD: begin
				cmd.prod = 1'b1;
				cnt_d    = '0;
				state_d  = ST_RUN;
			end
			ST_RUN: begin
				// basis of band n is registered in b_s1 before it is applied
				cmd.band     = cnt_q;
				cmd.basis_en = (cnt_q <= last);
				cmd.apply_en = (cnt_q != '0);
				cnt_d        = cnt_q + BIW'(1);
				if (cnt_q == last + BIW'(1))
					state_d = (op_q == OP_QRY) ? ST_FIN : ST_IDLE;
			end
			ST_FIN: begin
				if (!out_valid_q || !out_stall) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q        <= OP_DIR;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load)
				op_q <= op_t'(op);
			cnt_q <= cnt_d;
			if (cmd.fin)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule
